[sv/dnle_pkg.sv]
// Package for the DNS name label encoder.
// Holds field widths, codes and the word types shared by all modules.
// No dependencies.
`default_nettype none
package dnle_pkg;

  localparam int unsigned ADDR_FIELD_W = 9;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned LEN_W        = 10;
  localparam int unsigned LABEL_W      = 7;
  localparam int unsigned NPOS_W       = 9;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 9;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned PTR_W        = 2;
  localparam int unsigned CNT_W        = 3;

  localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
  localparam logic [BYTE_W-1:0] NUL_CHAR  = 8'h00;
  localparam logic [NPOS_W-1:0] POS_LIMIT = 9'd511;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LABEL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NAME  = 8'd1;

  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic [ADDR_FIELD_W-1:0] write_address;
    logic [BYTE_W-1:0]       write_byte;
    logic                    is_last;
    logic                    error;
    logic [LEN_W-1:0]        name_length;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [LABEL_W-1:0] max_label_length;
    logic [NPOS_W-1:0]  max_name_position;
  } cfg_t;

endpackage
`default_nettype wire

[sv/dnle_if.sv]
// Channel interfaces for the DNS name label encoder.
// Text input, encoded write output and register write channels.
// Depends on dnle_pkg.
`default_nettype none
interface dnle_text_if;
  logic                          valid;
  logic                          ready;
  logic [dnle_pkg::BYTE_W-1:0]   text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface dnle_wr_if;
  logic                                valid;
  logic                                ready;
  logic [dnle_pkg::ADDR_FIELD_W-1:0]   write_address;
  logic [dnle_pkg::BYTE_W-1:0]         write_byte;
  logic                                is_last;
  logic                                error;
  logic [dnle_pkg::LEN_W-1:0]          name_length;
  modport source (output valid, output write_address, output write_byte,
                  output is_last, output error, output name_length, input ready);
  modport sink   (input valid, input write_address, input write_byte,
                  input is_last, input error, input name_length, output ready);
endinterface

interface dnle_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [dnle_pkg::CFG_IDX_W-1:0]     index;
  logic [dnle_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/dns_name_label_encoder_core.sv]
// Top level of the DNS name label encoder.
// Depends on dnle_pkg, dnle_if, dnle_cfg_regs, dnle_encode, dnle_res_fifo.
//
//   channel  dir  payload                                         one word
//   text_i   in   text_byte                                       one character
//   wr_o     out  write_address write_byte is_last error name_len one encoded byte
//   cfg_i    in   index data                                      one register write
//
// One text word a cycle while the result queue has room; a word enters a register and its writes
// are made from that register into a four-word result queue. The end of a name gives two writes,
// so a burst of ends is held back by the single output port.
// Reset clears the name state and loads the limits 63 and 255.
// Output stalls back up through the queue to text_i.ready.
`default_nettype none
module dns_name_label_encoder_core #(
  parameter int unsigned ADDR_WIDTH = 9
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  dnle_text_if.sink  text_i,
  dnle_wr_if.source  wr_o,
  dnle_cfg_if.sink   cfg_i
);

  dnle_pkg::cfg_t  cfg;
  dnle_pkg::push_t push;
  logic            room;

  dnle_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  dnle_encode #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_encode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_i),
    .cfg_i  (cfg),
    .room_i (room),
    .push_o (push)
  );

  dnle_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .wr_o   (wr_o)
  );

endmodule
`default_nettype wire

[sv/dnle_cfg_regs.sv]
// Configuration registers of the DNS name label encoder.
// Decodes register writes into the limit values. Depends on dnle_pkg, dnle_if.
`default_nettype none
module dnle_cfg_regs (
  input  wire               clk_i,
  input  wire               rst_ni,
  dnle_cfg_if.sink          cfg_i,
  output dnle_pkg::cfg_t    cfg_o
);

  logic [dnle_pkg::LABEL_W-1:0] max_label_q, max_label_d;
  logic [dnle_pkg::NPOS_W-1:0]  max_name_q, max_name_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    max_label_d = max_label_q;
    max_name_d  = max_name_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dnle_pkg::CFG_MAX_LABEL: max_label_d = cfg_i.data[dnle_pkg::LABEL_W-1:0];
        dnle_pkg::CFG_MAX_NAME:  max_name_d  = cfg_i.data[dnle_pkg::NPOS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_label_q <= 7'd63;
      max_name_q  <= 9'd255;
    end else begin
      max_label_q <= max_label_d;
      max_name_q  <= max_name_d;
    end
  end

  assign cfg_o.max_label_length  = max_label_q;
  assign cfg_o.max_name_position = max_name_q;

endmodule
`default_nettype wire

[sv/dnle_encode.sv]
// Encoding stage of the DNS name label encoder.
// Input word register, name state and the per-byte write generation.
// Depends on dnle_pkg, dnle_if.
`default_nettype none
module dnle_encode #(
  parameter int unsigned ADDR_WIDTH = 9
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  dnle_text_if.sink         text_i,
  input  dnle_pkg::cfg_t    cfg_i,
  input  wire               room_i,
  output dnle_pkg::push_t   push_o
);

  localparam int unsigned AF_W = dnle_pkg::ADDR_FIELD_W;
  localparam int unsigned LF_W = dnle_pkg::LEN_W;
  localparam int unsigned LB_W = dnle_pkg::LABEL_W;
  localparam logic [ADDR_WIDTH-1:0] ADDR_MAX = {ADDR_WIDTH{1'b1}};
  localparam logic [ADDR_WIDTH-1:0] ADDR_ONE = ADDR_WIDTH'(1);

  logic                          byte_vld_q;
  logic [dnle_pkg::BYTE_W-1:0]   byte_q;
  logic [ADDR_WIDTH-1:0]         label_start_q, label_start_d;
  logic [ADDR_WIDTH-1:0]         out_pos_q, out_pos_d;
  logic [LB_W-1:0]               label_cnt_q, label_cnt_d;
  logic [dnle_pkg::NPOS_W-1:0]   in_pos_q, in_pos_d, in_pos_inc;
  logic                          after_dot_q, after_dot_d;
  logic                          discard_q, discard_d;
  logic                          fire;
  logic [LB_W:0]                 next_cnt;
  logic                          char_bad;
  logic [ADDR_WIDTH:0]           start_len, out_len;

  assign fire         = byte_vld_q && room_i;
  assign text_i.ready = !byte_vld_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (text_i.ready) begin
      byte_vld_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.ready && text_i.valid) begin
      byte_q <= text_i.text_byte;
    end
  end

  assign next_cnt   = {1'b0, label_cnt_q} + (LB_W+1)'(1);
  assign char_bad   = (next_cnt > {1'b0, cfg_i.max_label_length})
                   || (in_pos_q >= cfg_i.max_name_position)
                   || (out_pos_q == ADDR_MAX);
  assign in_pos_inc = (in_pos_q == dnle_pkg::POS_LIMIT) ? in_pos_q : in_pos_q + 9'd1;
  assign start_len  = {1'b0, label_start_q} + (ADDR_WIDTH+1)'(1);
  assign out_len    = {1'b0, out_pos_q} + (ADDR_WIDTH+1)'(1);

  always_comb begin
    label_start_d = label_start_q;
    out_pos_d     = out_pos_q;
    label_cnt_d   = label_cnt_q;
    in_pos_d      = in_pos_q;
    after_dot_d   = after_dot_q;
    discard_d     = discard_q;
    push_o        = '0;
    if (fire) begin
      if (discard_q) begin
        if (byte_q == dnle_pkg::NUL_CHAR) begin
          label_start_d = '0;
          out_pos_d     = ADDR_ONE;
          label_cnt_d   = '0;
          in_pos_d      = '0;
          after_dot_d   = 1'b0;
          discard_d     = 1'b0;
        end
      end else if (byte_q == dnle_pkg::NUL_CHAR) begin
        if (after_dot_q) begin
          push_o.n                = dnle_pkg::PUSH_ONE;
          push_o.r0.write_address = AF_W'(label_start_q);
          push_o.r0.is_last       = 1'b1;
          push_o.r0.name_length   = LF_W'(start_len);
        end else begin
          push_o.n                = dnle_pkg::PUSH_TWO;
          push_o.r0.write_address = AF_W'(label_start_q);
          push_o.r0.write_byte    = {1'b0, label_cnt_q};
          push_o.r1.write_address = AF_W'(out_pos_q);
          push_o.r1.is_last       = 1'b1;
          push_o.r1.name_length   = LF_W'(out_len);
        end
        label_start_d = '0;
        out_pos_d     = ADDR_ONE;
        label_cnt_d   = '0;
        in_pos_d      = '0;
        after_dot_d   = 1'b0;
      end else if ((byte_q == dnle_pkg::DOT_CHAR && out_pos_q == ADDR_MAX)
                || (byte_q != dnle_pkg::DOT_CHAR && char_bad)) begin
        push_o.n          = dnle_pkg::PUSH_ONE;
        push_o.r0.is_last = 1'b1;
        push_o.r0.error   = 1'b1;
        discard_d         = 1'b1;
      end else if (byte_q == dnle_pkg::DOT_CHAR) begin
        push_o.n                = dnle_pkg::PUSH_ONE;
        push_o.r0.write_address = AF_W'(label_start_q);
        push_o.r0.write_byte    = {1'b0, label_cnt_q};
        label_start_d = out_pos_q;
        out_pos_d     = out_pos_q + ADDR_ONE;
        label_cnt_d   = '0;
        after_dot_d   = 1'b1;
        in_pos_d      = in_pos_inc;
      end else begin
        push_o.n                = dnle_pkg::PUSH_ONE;
        push_o.r0.write_address = AF_W'(out_pos_q);
        push_o.r0.write_byte    = byte_q;
        out_pos_d     = out_pos_q + ADDR_ONE;
        label_cnt_d   = next_cnt[LB_W-1:0];
        after_dot_d   = 1'b0;
        in_pos_d      = in_pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_start_q <= '0;
      out_pos_q     <= ADDR_ONE;
      label_cnt_q   <= '0;
      in_pos_q      <= '0;
      after_dot_q   <= 1'b0;
      discard_q     <= 1'b0;
    end else begin
      label_start_q <= label_start_d;
      out_pos_q     <= out_pos_d;
      label_cnt_q   <= label_cnt_d;
      in_pos_q      <= in_pos_d;
      after_dot_q   <= after_dot_d;
      discard_q     <= discard_d;
    end
  end

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.n != dnle_pkg::PUSH_NONE && push_o.r0.error) |-> push_o.r0.is_last)
    else $error("error word not marked last");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && byte_q == dnle_pkg::NUL_CHAR) |=>
      (out_pos_q == ADDR_ONE && label_start_q == '0 && !discard_q))
    else $error("name state not cleared at end of name");

  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && discard_q) |-> (push_o.n == dnle_pkg::PUSH_NONE))
    else $error("write produced while dropping input");

endmodule
`default_nettype wire

[sv/dnle_res_fifo.sv]
// Result queue of the DNS name label encoder.
// Takes up to two write words a cycle and hands out one. Depends on dnle_pkg, dnle_if.
`default_nettype none
module dnle_res_fifo (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  dnle_pkg::push_t   push_i,
  output logic              room_o,
  dnle_wr_if.source         wr_o
);

  localparam int unsigned PW = dnle_pkg::PTR_W;
  localparam int unsigned CW = dnle_pkg::CNT_W;

  dnle_pkg::res_t  mem_q [dnle_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q, count_d;
  logic            pop;
  dnle_pkg::res_t  head;

  assign pop    = wr_o.valid && wr_o.ready;
  assign room_o = (count_q <= CW'(dnle_pkg::FIFO_DEPTH - 2))
               || (count_q == CW'(dnle_pkg::FIFO_DEPTH - 1) && pop);
  assign count_d = count_q + CW'(push_i.n) - CW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(push_i.n);
      rd_ptr_q <= rd_ptr_q + PW'(pop);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != dnle_pkg::PUSH_NONE) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == dnle_pkg::PUSH_TWO) begin
      mem_q[wr_ptr_q + PW'(1)] <= push_i.r1;
    end
  end

  assign head               = mem_q[rd_ptr_q];
  assign wr_o.valid         = (count_q != '0);
  assign wr_o.write_address = head.write_address;
  assign wr_o.write_byte    = head.write_byte;
  assign wr_o.is_last       = head.is_last;
  assign wr_o.error         = head.error;
  assign wr_o.name_length   = head.name_length;

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(dnle_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != dnle_pkg::PUSH_NONE && !pop) |=> (count_q > $past(count_q)))
    else $error("result queue lost a word");

endmodule
`default_nettype wire

[test/dns_name_label_encoder_core_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for dns_name_label_encoder_core: random dotted names, register sweeps,
// an in-bench encoder that predicts every addressed write, and a scoreboard that checks them.
// Depends on dnle_pkg, dnle_if and the encoder RTL.
module dns_name_label_encoder_core_test;

  localparam int unsigned ADDR_FIELD_W = dnle_pkg::ADDR_FIELD_W;
  localparam int unsigned BYTE_W       = dnle_pkg::BYTE_W;
  localparam int unsigned LEN_W        = dnle_pkg::LEN_W;
  localparam int unsigned LABEL_W      = dnle_pkg::LABEL_W;
  localparam int unsigned NPOS_W       = dnle_pkg::NPOS_W;
  localparam int unsigned CFG_IDX_W    = dnle_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W   = dnle_pkg::CFG_DATA_W;

  localparam logic [ADDR_FIELD_W-1:0] ADDR_LAST = {ADDR_FIELD_W{1'b1}};
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned IDLE_GAP       = 12;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned NUM_PHASES     = 10;
  localparam int unsigned PHASE_ITEMS    = 100;

  typedef enum int unsigned {RX_STEADY, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_e;

  class label_scoreboard;
    dnle_pkg::res_t          pending_writes[$];
    int unsigned             errors;
    int unsigned             words_noted;
    int unsigned             writes_checked;
    int unsigned             names_done;
    int unsigned             names_rejected;
    logic [LABEL_W-1:0]      max_label;
    logic [NPOS_W-1:0]       max_name;
    logic [ADDR_FIELD_W-1:0] label_start;
    logic [ADDR_FIELD_W-1:0] out_pos;
    logic [NPOS_W-1:0]       in_pos;
    int unsigned             label_cnt;
    bit                      after_dot;
    bit                      discarding;

    function new();
      max_label = 7'd63;
      max_name  = 9'd255;
      clear_name();
    endfunction

    function void clear_name();
      label_start = '0;
      out_pos     = ADDR_FIELD_W'(1);
      label_cnt   = 0;
      in_pos      = '0;
      after_dot   = 1'b0;
      discarding  = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == dnle_pkg::CFG_MAX_LABEL) begin
        max_label = val[LABEL_W-1:0];
      end else if (idx == dnle_pkg::CFG_MAX_NAME) begin
        max_name = val[NPOS_W-1:0];
      end
    endfunction

    function void add_write(logic [ADDR_FIELD_W-1:0] addr, logic [BYTE_W-1:0] wbyte,
                            logic last, logic err, logic [LEN_W-1:0] len);
      dnle_pkg::res_t w;
      w.write_address = addr;
      w.write_byte    = wbyte;
      w.is_last       = last;
      w.error         = err;
      w.name_length   = len;
      pending_writes.push_back(w);
    endfunction

    function void reject();
      add_write('0, '0, 1'b1, 1'b1, '0);
      names_rejected++;
      discarding = 1'b1;
    endfunction

    function void bump_pos();
      if (in_pos < dnle_pkg::POS_LIMIT) in_pos++;
    endfunction

    function void encode_char(logic [BYTE_W-1:0] c);
      words_noted++;
      if (discarding) begin
        if (c == dnle_pkg::NUL_CHAR) clear_name();
        return;
      end
      if (c == dnle_pkg::NUL_CHAR) begin
        names_done++;
        if (after_dot) begin
          add_write(label_start, '0, 1'b1, 1'b0, {1'b0, label_start} + 10'd1);
        end else begin
          add_write(label_start, BYTE_W'(label_cnt), 1'b0, 1'b0, '0);
          add_write(out_pos, '0, 1'b1, 1'b0, {1'b0, out_pos} + 10'd1);
        end
        clear_name();
        return;
      end
      if (c == dnle_pkg::DOT_CHAR) begin
        if (out_pos == ADDR_LAST) begin
          reject();
          return;
        end
        add_write(label_start, BYTE_W'(label_cnt), 1'b0, 1'b0, '0);
        label_start = out_pos;
        out_pos     = out_pos + 1'b1;
        label_cnt   = 0;
        after_dot   = 1'b1;
        bump_pos();
        return;
      end
      if (label_cnt + 1 > max_label || in_pos >= max_name || out_pos == ADDR_LAST) begin
        reject();
        return;
      end
      add_write(out_pos, c, 1'b0, 1'b0, '0);
      out_pos   = out_pos + 1'b1;
      label_cnt = label_cnt + 1;
      after_dot = 1'b0;
      bump_pos();
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_write(dnle_pkg::res_t got);
      dnle_pkg::res_t want;
      writes_checked++;
      if (pending_writes.size() == 0) begin
        $error("write with nothing pending: addr %0d byte %0d last %0b err %0b len %0d",
               got.write_address, got.write_byte, got.is_last, got.error, got.name_length);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      compare_field("write_address", want.write_address, got.write_address);
      compare_field("write_byte", want.write_byte, got.write_byte);
      compare_field("is_last", want.is_last, got.is_last);
      compare_field("error", want.error, got.error);
      compare_field("name_length", want.name_length, got.name_length);
    endfunction

    function int unsigned pending();
      return pending_writes.size();
    endfunction

    function void close();
      if (pending_writes.size() != 0) begin
        $error("%0d writes never arrived", pending_writes.size());
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dnle_text_if text_if ();
  dnle_wr_if   wr_if ();
  dnle_cfg_if  cfg_if ();

  dns_name_label_encoder_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_if),
    .wr_o   (wr_if),
    .cfg_i  (cfg_if)
  );

  label_scoreboard sb = new();
  logic [BYTE_W-1:0] text_q[$];
  int unsigned queued_words;
  int unsigned reg_writes;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if ((text_if.valid && text_if.ready) || (wr_if.valid && wr_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : text_driver
    int unsigned burst_left;
    int unsigned gap_left;
    bit          hold;
    burst_left = 0;
    gap_left   = 0;
    text_if.valid     <= 1'b0;
    text_if.text_byte <= '0;
    forever begin
      @(posedge clk_i);
      hold = text_if.valid && !text_if.ready;
      if (text_if.valid && text_if.ready) begin
        sb.encode_char(text_if.text_byte);
        void'(text_q.pop_front());
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
          text_if.valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          text_if.valid     <= 1'b1;
          text_if.text_byte <= text_q[0];
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
          end
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  initial begin : write_receiver
    dnle_pkg::res_t got;
    rx_mode_e       mode;
    int unsigned    mode_left;
    int unsigned    stall_left;
    mode       = RX_STEADY;
    mode_left  = 0;
    stall_left = 0;
    wr_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (wr_if.valid && wr_if.ready) begin
        got.write_address = wr_if.write_address;
        got.write_byte    = wr_if.write_byte;
        got.is_last       = wr_if.is_last;
        got.error         = wr_if.error;
        got.name_length   = wr_if.name_length;
        sb.check_write(got);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 400);
      end
      mode_left--;
      case (mode)
        RX_STEADY: wr_if.ready <= 1'b1;
        RX_COIN:   wr_if.ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: wr_if.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            wr_if.ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(5, 24);
            wr_if.ready <= 1'b0;
          end else begin
            wr_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  function automatic logic [BYTE_W-1:0] rand_char();
    logic [BYTE_W-1:0] ch;
    ch = BYTE_W'($urandom_range(1, 255));
    while (ch == dnle_pkg::DOT_CHAR) ch = BYTE_W'($urandom_range(1, 255));
    return ch;
  endfunction

  task automatic push_text(input logic [BYTE_W-1:0] b);
    text_q.push_back(b);
    queued_words++;
  endtask

  task automatic queue_label(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_text(rand_char());
  endtask

  task automatic wait_idle(input int unsigned extra);
    while (text_q.size() != 0 || sb.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!(cfg_if.valid && cfg_if.ready)) @(posedge clk_i);
    sb.write_reg(idx, val);
    reg_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : main_flow
    logic [CFG_DATA_W-1:0] lab_val;
    logic [CFG_DATA_W-1:0] name_val;
    int unsigned           phase_start;
    int unsigned           long_start;
    int unsigned           lim;
    int unsigned           kind;
    int unsigned           nlab;
    int unsigned           len;
    int unsigned           r;
    bit                    force_long;
    quiet_cycles = 0;
    queued_words = 0;
    reg_writes   = 0;
    rst_ni       <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty name, lone dot, double dot, trailing dot, byte extremes
    push_text(dnle_pkg::NUL_CHAR);
    push_text(dnle_pkg::DOT_CHAR);
    push_text(dnle_pkg::NUL_CHAR);
    push_text(8'h61);
    push_text(dnle_pkg::DOT_CHAR);
    push_text(dnle_pkg::DOT_CHAR);
    push_text(8'h62);
    push_text(dnle_pkg::NUL_CHAR);
    push_text(8'h78);
    push_text(dnle_pkg::DOT_CHAR);
    push_text(dnle_pkg::NUL_CHAR);
    push_text(8'hFF);
    push_text(8'h01);
    push_text(dnle_pkg::NUL_CHAR);
    wait_idle(IDLE_GAP);

    // label too long, then name too long, with drops after each
    write_reg(dnle_pkg::CFG_MAX_LABEL, 9'd2);
    write_reg(dnle_pkg::CFG_MAX_NAME, 9'd4);
    push_text(8'h61);
    push_text(8'h62);
    push_text(8'h63);
    push_text(dnle_pkg::DOT_CHAR);
    push_text(dnle_pkg::NUL_CHAR);
    push_text(8'h61);
    push_text(dnle_pkg::DOT_CHAR);
    push_text(8'h62);
    push_text(dnle_pkg::DOT_CHAR);
    push_text(8'h63);
    push_text(dnle_pkg::NUL_CHAR);

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle(IDLE_GAP);
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_IDX_W'($urandom_range(dnle_pkg::CFG_MAX_NAME + 1, {CFG_IDX_W{1'b1}})),
                  CFG_DATA_W'($urandom_range(0, 511)));
      end
      case (ph)
        0:       begin lab_val = 9'd127; name_val = 9'd511; end
        1:       begin lab_val = 9'd1;   name_val = 9'd1;   end
        2:       begin lab_val = 9'd128; name_val = 9'd300; end
        3:       begin lab_val = 9'd63;  name_val = 9'd0;   end
        4:       begin lab_val = 9'd511; name_val = 9'd510; end
        9:       begin lab_val = 9'd63;  name_val = 9'd255; end
        default: begin
          lab_val  = CFG_DATA_W'($urandom_range(0, 511));
          name_val = CFG_DATA_W'($urandom_range(0, 511));
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        write_reg(dnle_pkg::CFG_MAX_LABEL, lab_val);
        write_reg(dnle_pkg::CFG_MAX_NAME, name_val);
      end else begin
        write_reg(dnle_pkg::CFG_MAX_NAME, name_val);
        write_reg(dnle_pkg::CFG_MAX_LABEL, lab_val);
      end
      lim         = sb.max_label;
      force_long  = (ph == 0 || ph == 4);
      phase_start = queued_words;
      while (queued_words - phase_start < PHASE_ITEMS) begin
        kind       = force_long ? 99 : $urandom_range(0, 99);
        force_long = 1'b0;
        if (kind < 70) begin
          nlab = $urandom_range(0, 4);
          for (int unsigned i = 0; i < nlab; i++) begin
            if (i > 0) push_text(dnle_pkg::DOT_CHAR);
            r = $urandom_range(0, 9);
            if (r == 0) len = lim + 1;
            else if (r == 1) len = lim;
            else len = $urandom_range(0, (lim < 8) ? lim : 8);
            queue_label(len);
          end
          if ($urandom_range(0, 4) == 0) push_text(dnle_pkg::DOT_CHAR);
        end else if (kind < 85) begin
          len = $urandom_range(1, 12);
          for (int unsigned i = 0; i < len; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0) push_text(dnle_pkg::NUL_CHAR);
            else if (r < 3) push_text(dnle_pkg::DOT_CHAR);
            else push_text(BYTE_W'($urandom_range(0, 255)));
          end
        end else if (kind < 98) begin
          queue_label(lim + $urandom_range(1, 3));
          len = $urandom_range(0, 6);
          for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 3) == 0) push_text(dnle_pkg::DOT_CHAR);
            else push_text(rand_char());
          end
        end else begin
          long_start = queued_words;
          if ($urandom_range(0, 1) == 1) begin
            while (queued_words - long_start < 515) push_text(dnle_pkg::DOT_CHAR);
          end else begin
            while (queued_words - long_start < 520) begin
              queue_label($urandom_range(0, lim));
              push_text(dnle_pkg::DOT_CHAR);
            end
          end
        end
        push_text(dnle_pkg::NUL_CHAR);
      end
    end

    wait_idle(TAIL_CYCLES);
    sb.close();
    $display("Covered %0d names (%0d rejected), %0d text words, %0d writes checked",
             sb.names_done + sb.names_rejected, sb.names_rejected, sb.words_noted,
             sb.writes_checked);
    $display("Register writes: %0d over %0d limit settings", reg_writes, NUM_PHASES + 2);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
